// ===== hdl/tods_pkg.sv =====
// Shared types and constants for the time-of-day slot table.
// Holds the input and result transaction structs, the slot entry layout and the codes.
// No dependencies.
`timescale 1ns / 1ps

package tods_pkg;

    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 6;
    localparam int SEC_W    = 6;
    localparam int MASK_W   = 5;
    localparam int TIME_W   = HOUR_W + MIN_W + SEC_W;
    localparam int DL_W     = 5;

    // Devices that carry flags; mask bits above this are dropped on a flag write.
    localparam int NUM_DEVICES = 5;
    localparam logic [MASK_W-1:0] DEV_MASK = MASK_W'((1 << NUM_DEVICES) - 1);

    localparam logic [DL_W-1:0] HOURS_PER_DAY  = DL_W'(24);
    localparam logic [DL_W-1:0] DAYLIGHT_RESET = DL_W'(12);

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_REMOVE = 3'd1,
        ACT_FIND   = 3'd2,
        ACT_WRITE  = 3'd3,
        ACT_READ   = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_DUP       = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_LAST_KEPT = 3'd4,
        STAT_BAD_INDEX = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT_UP,
        S_PLACE,
        S_SHIFT_DN,
        S_WALK,
        S_WALK_LAST,
        S_FLAGS,
        S_FETCH,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [2:0]        slot_index;
        logic [MASK_W-1:0] auto_mask;
        logic [MASK_W-1:0] state_mask;
        logic [MASK_W-1:0] periodic_mask;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [2:0]        result_slot;
        logic [3:0]        slot_count;
        logic [HOUR_W-1:0] out_hour;
        logic [MIN_W-1:0]  out_minute;
        logic [SEC_W-1:0]  out_second;
        logic [MASK_W-1:0] out_auto;
        logic [MASK_W-1:0] out_state;
        logic [MASK_W-1:0] out_periodic;
    } out_item_t;

    typedef struct packed {
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic [SEC_W-1:0]  second;
        logic [MASK_W-1:0] auto_f;
        logic [MASK_W-1:0] onoff;
        logic [MASK_W-1:0] periodic;
    } slot_entry_t;

endpackage

// ===== hdl/time_of_day_slot_table.sv =====
// Time-of-day slot table: sorted slot store with one read and one write port, table walker and result register.
// Depends on tods_pkg.
`timescale 1ns / 1ps

// The table holds up to MAX_SLOTS daily slots sorted by start time in an
// array with one read and one write port, and one small sequencer walks it one
// entry per cycle for every transaction. An insert scans the table for a
// duplicate and its place, then shifts the tail up one entry a cycle; a
// remove scans and shifts the tail down; a lookup reads the entries in order
// until one holds the time. The longest transaction is an insert at the front
// of a table with MAX_SLOTS-1 entries. s_ready is high only while the sequencer
// is idle, which it enters as the result is loaded, and the result register lets
// the next transaction be accepted while the previous result is still waiting
// on m_ready. The daylight register is written through the cfg channel, which
// is always ready; write it only while no transaction is in flight.
module time_of_day_slot_table #(
    parameter int MAX_SLOTS = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tods_pkg::in_item_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output tods_pkg::out_item_t m_payload,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [4:0]          cfg_data
);
    import tods_pkg::*;

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int SW = (IW > 3) ? IW : 3;
    localparam int XW = (CW > 3) ? CW : 3;

    slot_entry_t slot_mem [MAX_SLOTS];

    state_t            state_reg, state_next;
    in_item_t          req_reg, req_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     pos_reg, pos_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     cur_reg, cur_next;
    slot_entry_t       prev_reg, prev_next;
    logic [TIME_W-1:0] first_time_reg, first_time_next;
    slot_entry_t       hold_reg, hold_next;
    logic              show_reg, show_next;
    status_t           res_status_reg, res_status_next;
    logic [SW-1:0]     res_slot_reg, res_slot_next;
    logic [DL_W-1:0]   daylight_reg, daylight_next;
    logic              m_valid_reg, m_valid_next;
    out_item_t         m_payload_reg, m_payload_next;
    slot_entry_t       rd_ent_reg;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    slot_entry_t       wr_ent;
    logic [IW-1:0]     rd_addr;
    slot_entry_t       rd_ent;

    logic [TIME_W-1:0] req_time, rd_time, ss_time, se_time;
    logic [CW-1:0]     idx_inc, idx_dec, count_dec, eval_slot;
    logic              hm_match, rd_less, scan_last, walk_last;
    logic              pair_equal, slot_hit, bad_index, out_free;

    // Entry that a step in the given state works on.
    function automatic logic [IW-1:0] read_addr(input state_t st, input logic [CW-1:0] idx,
                                                input logic [CW-1:0] pos,
                                                input logic [2:0] sel,
                                                input logic [SW-1:0] res_slot);
        logic [IW-1:0] addr;
        unique case (st)
            S_SCAN, S_WALK: addr = idx[IW-1:0];
            S_SHIFT_UP:     addr = IW'(idx - CW'(1));
            S_SHIFT_DN:     addr = IW'(idx + CW'(1));
            S_PLACE: begin
                if (pos == '0) begin
                    addr = IW'(1);
                end else begin
                    addr = IW'(pos - CW'(1));
                end
            end
            S_FLAGS:        addr = IW'(sel);
            S_FETCH:        addr = res_slot[IW-1:0];
            default:        addr = '0;
        endcase
        return addr;
    endfunction

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // The read is registered, so the address is taken from the next step's values.
    assign rd_addr   = read_addr(state_next, idx_next, pos_next, req_next.slot_index,
                                 res_slot_next);
    assign rd_ent    = rd_ent_reg;
    assign req_time  = {req_reg.hour, req_reg.minute, req_reg.second};
    assign rd_time   = {rd_ent.hour, rd_ent.minute, rd_ent.second};
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign count_dec = count_reg - CW'(1);
    assign hm_match  = (rd_ent.hour == req_reg.hour) && (rd_ent.minute == req_reg.minute);
    assign rd_less   = (rd_time < req_time);
    assign scan_last = (idx_reg == count_dec);
    assign walk_last = (idx_reg == count_dec);
    assign bad_index = (XW'(req_reg.slot_index) >= XW'(count_reg));
    assign out_free  = !m_valid_reg || m_ready;

    // Lookup compares slot eval_slot (start ss) against the next slot's start se,
    // which wraps to the first entry for the last slot.
    assign ss_time    = {prev_reg.hour, prev_reg.minute, prev_reg.second};
    assign se_time    = (state_reg == S_WALK_LAST) ? first_time_reg : rd_time;
    assign eval_slot  = (state_reg == S_WALK_LAST) ? count_dec : idx_dec;
    assign pair_equal = (count_reg == CW'(2)) && (ss_time == se_time);

    always_comb begin
        if (pair_equal) begin
            slot_hit = ((daylight_reg == HOURS_PER_DAY) && (eval_slot == CW'(0)))
                    || ((daylight_reg == '0) && (eval_slot == CW'(1)));
        end else begin
            slot_hit = ((req_time >= ss_time) && (req_time < se_time))
                    || ((se_time < ss_time) && (req_time >= ss_time))
                    || ((se_time < ss_time) && (req_time < se_time));
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_START;
                end
            end
            S_START: begin
                unique case (req_reg.action)
                    ACT_INSERT: state_next = (count_reg >= CW'(MAX_SLOTS)) ? S_DONE : S_SCAN;
                    ACT_REMOVE: state_next = (count_reg <= CW'(1)) ? S_FETCH : S_SCAN;
                    ACT_FIND:   state_next = (count_reg == CW'(1)) ? S_FETCH : S_WALK;
                    ACT_WRITE:  state_next = bad_index ? S_DONE : S_FLAGS;
                    ACT_READ:   state_next = bad_index ? S_DONE : S_FETCH;
                    default:    state_next = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (req_reg.action == ACT_INSERT) begin
                    if (hm_match) begin
                        state_next = S_DONE;
                    end else if (scan_last) begin
                        state_next = S_SHIFT_UP;
                    end
                end else begin
                    if (hm_match) begin
                        state_next = S_SHIFT_DN;
                    end else if (scan_last) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT_UP: begin
                if (idx_reg <= pos_reg) begin
                    state_next = S_PLACE;
                end
            end
            S_PLACE:    state_next = S_DONE;
            S_SHIFT_DN: begin
                if (idx_inc >= count_reg) begin
                    state_next = S_DONE;
                end
            end
            S_WALK: begin
                if (idx_reg != '0) begin
                    if (slot_hit) begin
                        state_next = S_DONE;
                    end else if (walk_last) begin
                        state_next = S_WALK_LAST;
                    end
                end
            end
            S_WALK_LAST: state_next = slot_hit ? S_DONE : S_FETCH;
            S_FLAGS:     state_next = S_FETCH;
            S_FETCH:     state_next = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath, table writes and result register.
    always_comb begin
        req_next        = req_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        found_next      = found_reg;
        cur_next        = cur_reg;
        prev_next       = prev_reg;
        first_time_next = first_time_reg;
        hold_next       = hold_reg;
        show_next       = show_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        daylight_next   = daylight_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_ent          = rd_ent;

        if (cfg_valid) begin
            daylight_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    req_next = s_payload;
                end
            end
            S_START: begin
                idx_next        = '0;
                found_next      = 1'b0;
                pos_next        = count_reg;
                res_status_next = STAT_OK;
                res_slot_next   = '0;
                show_next       = 1'b1;
                unique case (req_reg.action)
                    ACT_INSERT: begin
                        if (count_reg >= CW'(MAX_SLOTS)) begin
                            res_status_next = STAT_FULL;
                            show_next       = 1'b0;
                        end
                    end
                    ACT_REMOVE: begin
                        if (count_reg <= CW'(1)) begin
                            res_status_next = STAT_LAST_KEPT;
                        end
                    end
                    ACT_FIND: begin
                        if (count_reg == CW'(1)) begin
                            cur_next = '0;
                        end
                    end
                    ACT_WRITE, ACT_READ: begin
                        res_slot_next = SW'(req_reg.slot_index);
                        if (bad_index) begin
                            res_status_next = STAT_BAD_INDEX;
                            show_next       = 1'b0;
                        end
                    end
                    default: begin
                        res_status_next = STAT_BAD_INDEX;
                        show_next       = 1'b0;
                    end
                endcase
            end
            S_SCAN: begin
                if (hm_match) begin
                    hold_next     = rd_ent;
                    res_slot_next = SW'(idx_reg);
                    pos_next      = idx_reg;
                    if (req_reg.action == ACT_INSERT) begin
                        res_status_next = STAT_DUP;
                    end
                end else begin
                    // The first entry that is not earlier than the new time is its place.
                    if (!rd_less && !found_reg) begin
                        pos_next   = idx_reg;
                        found_next = 1'b1;
                    end
                    if (scan_last) begin
                        if (req_reg.action == ACT_INSERT) begin
                            idx_next = count_reg;
                        end else begin
                            res_status_next = STAT_NOT_FOUND;
                            show_next       = 1'b0;
                        end
                    end else begin
                        idx_next = idx_inc;
                    end
                end
            end
            S_SHIFT_UP: begin
                if (idx_reg > pos_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[IW-1:0];
                    wr_ent   = rd_ent;
                    idx_next = idx_dec;
                end
            end
            S_PLACE: begin
                wr_en         = 1'b1;
                wr_addr       = pos_reg[IW-1:0];
                wr_ent.hour   = req_reg.hour;
                wr_ent.minute = req_reg.minute;
                wr_ent.second = req_reg.second;
                hold_next     = wr_ent;
                count_next    = count_reg + CW'(1);
                res_slot_next = SW'(pos_reg);
            end
            S_SHIFT_DN: begin
                if (idx_inc < count_reg) begin
                    wr_en    = 1'b1;
                    wr_addr  = idx_reg[IW-1:0];
                    wr_ent   = rd_ent;
                    idx_next = idx_inc;
                end else begin
                    count_next = count_dec;
                    if (CW'(cur_reg) >= count_dec) begin
                        cur_next = IW'(count_reg - CW'(2));
                    end
                end
            end
            S_WALK: begin
                if (idx_reg == '0) begin
                    first_time_next = rd_time;
                    prev_next       = rd_ent;
                    idx_next        = idx_inc;
                end else if (slot_hit) begin
                    cur_next      = IW'(eval_slot);
                    res_slot_next = SW'(eval_slot);
                    hold_next     = prev_reg;
                end else begin
                    prev_next = rd_ent;
                    if (!walk_last) begin
                        idx_next = idx_inc;
                    end
                end
            end
            S_WALK_LAST: begin
                if (slot_hit) begin
                    cur_next      = IW'(eval_slot);
                    res_slot_next = SW'(eval_slot);
                    hold_next     = prev_reg;
                end else begin
                    res_status_next = STAT_NOT_FOUND;
                    res_slot_next   = SW'(cur_reg);
                end
            end
            S_FLAGS: begin
                wr_en           = 1'b1;
                wr_addr         = IW'(req_reg.slot_index);
                wr_ent.auto_f   = req_reg.auto_mask & DEV_MASK;
                wr_ent.onoff    = req_reg.state_mask & DEV_MASK;
                wr_ent.periodic = req_reg.periodic_mask & DEV_MASK;
            end
            S_FETCH: begin
                hold_next = rd_ent;
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next               = 1'b1;
                    m_payload_next.status      = res_status_reg;
                    m_payload_next.result_slot = res_slot_reg[2:0];
                    m_payload_next.slot_count  = 4'(count_reg);
                    if (show_reg) begin
                        m_payload_next.out_hour     = hold_reg.hour;
                        m_payload_next.out_minute   = hold_reg.minute;
                        m_payload_next.out_second   = hold_reg.second;
                        m_payload_next.out_auto     = hold_reg.auto_f;
                        m_payload_next.out_state    = hold_reg.onoff;
                        m_payload_next.out_periodic = hold_reg.periodic;
                    end else begin
                        m_payload_next.out_hour     = '0;
                        m_payload_next.out_minute   = '0;
                        m_payload_next.out_second   = '0;
                        m_payload_next.out_auto     = '0;
                        m_payload_next.out_state    = '0;
                        m_payload_next.out_periodic = '0;
                    end
                end
            end
            default: begin
                req_next = req_reg;
            end
        endcase
    end

    // Only the first entry has a defined value after reset. A write to the entry
    // being read is passed straight to the read register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_mem[0] <= '0;
            rd_ent_reg  <= '0;
        end else begin
            if (wr_en) begin
                slot_mem[wr_addr] <= wr_ent;
            end
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_ent_reg <= wr_ent;
            end else begin
                rd_ent_reg <= slot_mem[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= CW'(1);
            cur_reg      <= '0;
            daylight_reg <= DAYLIGHT_RESET;
            m_valid_reg  <= 1'b0;
            found_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cur_reg      <= cur_next;
            daylight_reg <= daylight_next;
            m_valid_reg  <= m_valid_next;
            found_reg    <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        prev_reg       <= prev_next;
        first_time_reg <= first_time_next;
        hold_reg       <= hold_next;
        show_reg       <= show_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        m_payload_reg  <= m_payload_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CW'(1)) && (count_reg <= CW'(MAX_SLOTS)))
        else $error("slot count left its legal range");

    a_current_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(cur_reg) < count_reg)
        else $error("current slot lies beyond the table");

    a_place_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PLACE) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("insert did not add exactly one entry");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE || state_reg == S_DONE) |-> !wr_en)
        else $error("table written outside a transaction");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside the final step");
`endif

endmodule
